FILE: rtl/secded_hamming_frame_encoder_assert.svh
// assertion macros for the secded frame encoder rtl
// no dependencies; included by sdhfe_framer, the module that carries assertions
`ifndef SECDED_HAMMING_FRAME_ENCODER_ASSERT_SVH
`define SECDED_HAMMING_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SDHFE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdhfe assertion failed");

// next-cycle implication, disabled during reset
`define SDHFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdhfe assertion failed");

`endif

FILE: rtl/sdhfe_pkg.sv
// shared constants and types for the secded hamming frame encoder
// no dependencies
package sdhfe_pkg;

   localparam int CW_BITS   = 128;
   localparam int CW_BYTES  = CW_BITS / 8;
   localparam int MSG_BITS  = 80;
   localparam int HIGH_BITS = 64;
   localparam int LOW_BITS  = MSG_BITS - HIGH_BITS;
   localparam int POS_W     = $clog2(CW_BITS);
   localparam int IDX_W     = $clog2(CW_BYTES);
   localparam int PAR_BITS  = POS_W;

   // framing bytes
   localparam logic [7:0] FRAME_START  = 8'hAA;
   localparam logic [7:0] FRAME_END    = 8'hBB;
   localparam logic [7:0] FRAME_ESCAPE = 8'hDD;

   // codeword handed from the encoder to the framer
   typedef struct packed {
      logic                valid;
      logic [CW_BITS-1:0]  codeword;
   } cw_offer_type;

endpackage

FILE: rtl/sdhfe_codeword.sv
// extended hamming (128,120) codeword builder, purely combinational
// depends on sdhfe_pkg
module sdhfe_codeword
   import sdhfe_pkg::*;
(
   input  logic                  msg_valid,
   input  logic [HIGH_BITS-1:0]  msg_high,
   input  logic [LOW_BITS-1:0]   msg_low,
   output cw_offer_type          offer
);

   logic [MSG_BITS-1:0] msg;
   logic [CW_BITS-1:0]  cw;

   assign msg = {msg_high, msg_low};

   // data placement, hamming parities, then overall parity at position 0
   always_comb begin
      int  k;
      logic par;
      logic all;
      cw = '0;
      k = 0;
      for (int p = 1; p < CW_BITS; p++) begin
         if ((p & (p - 1)) != 0) begin
            if (k < MSG_BITS) begin
               cw[POS_W'(p)] = msg[POS_W'(MSG_BITS - 1 - k)];
            end
            k++;
         end
      end
      for (int b = 0; b < PAR_BITS; b++) begin
         par = 1'b0;
         for (int p = 1; p < CW_BITS; p++) begin
            if ((((p >> b) & 1) != 0) && (p != (1 << b))) begin
               par = par ^ cw[POS_W'(p)];
            end
         end
         cw[POS_W'(1 << b)] = par;
      end
      all = 1'b0;
      for (int p = 1; p < CW_BITS; p++) begin
         all = all ^ cw[POS_W'(p)];
      end
      cw[0] = all;
   end

   assign offer.valid    = msg_valid;
   assign offer.codeword = cw;

endmodule

FILE: rtl/sdhfe_framer.sv
// codeword register, byte stuffing sequencer and output register
// depends on sdhfe_pkg and secded_hamming_frame_encoder_assert.svh
`include "secded_hamming_frame_encoder_assert.svh"

module sdhfe_framer
   import sdhfe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cw_offer_type  offer,
   output logic          take,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_frame_byte,
   output logic          rsp_frame_last
);

   typedef enum logic [1:0] {
      PH_START,
      PH_DATA,
      PH_END
   } phase_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CW_BYTES - 1);

   phase_type          phase_ff, phase_in;
   logic               active_ff, active_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               esc_ff, esc_in;
   logic [CW_BITS-1:0] cw_ff, cw_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [7:0]         cur_byte;
   logic               cur_special;
   logic               advance;

   // current codeword byte, lowest position in the msb
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         cur_byte[7 - j] = cw_ff[{idx_ff, 3'(j)}];
      end
   end

   assign cur_special = (cur_byte == FRAME_START) || (cur_byte == FRAME_END) ||
                        (cur_byte == FRAME_ESCAPE);

   // output register free or being drained this cycle
   assign advance = !rsp_valid_ff || rsp_ready;

   // sequencer next state
   always_comb begin
      phase_in     = phase_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      esc_in       = esc_ff;
      cw_in        = cw_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      take         = 1'b0;
      if (advance) begin
         rsp_valid_in = 1'b0;
         if (active_ff) begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b0;
            case (phase_ff)
               PH_START: begin
                  rsp_byte_in = FRAME_START;
                  phase_in    = PH_DATA;
                  idx_in      = '0;
                  esc_in      = 1'b0;
               end
               PH_DATA: begin
                  if (cur_special && !esc_ff) begin
                     rsp_byte_in = FRAME_ESCAPE;
                     esc_in      = 1'b1;
                  end else begin
                     rsp_byte_in = cur_byte;
                     esc_in      = 1'b0;
                     idx_in      = idx_ff + 1'b1;
                     if (idx_ff == LAST_IDX) begin
                        phase_in = PH_END;
                     end
                  end
               end
               PH_END: begin
                  rsp_byte_in = FRAME_END;
                  rsp_last_in = 1'b1;
                  phase_in    = PH_START;
                  idx_in      = '0;
                  esc_in      = 1'b0;
                  active_in   = offer.valid;
                  take        = offer.valid;
                  if (offer.valid) begin
                     cw_in = offer.codeword;
                  end
               end
               default: begin
                  phase_in  = PH_START;
                  active_in = 1'b0;
               end
            endcase
         end else if (offer.valid) begin
            take      = 1'b1;
            active_in = 1'b1;
            cw_in     = offer.codeword;
            phase_in  = PH_START;
            idx_in    = '0;
            esc_in    = 1'b0;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         esc_ff       <= esc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cw_ff       <= cw_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_frame_last = rsp_last_ff;

   // a closing flag only ever rides on the end byte
   `SDHFE_ASSERT_NOW(a_last_is_end, clock, reset, rsp_valid_ff && rsp_last_ff,
      rsp_byte_ff == FRAME_END)
   // a pending escape always sits on a byte that needs one
   `SDHFE_ASSERT_NOW(a_esc_on_special, clock, reset, esc_ff, cur_special && phase_ff == PH_DATA)
   // escaping a special byte loads the escape byte into the output register with the escape pending
   `SDHFE_ASSERT_NEXT(a_esc_then_byte, clock, reset,
      advance && active_ff && phase_ff == PH_DATA && cur_special && !esc_ff,
      rsp_valid_ff && rsp_byte_ff == FRAME_ESCAPE && esc_ff)
   // a new codeword is only taken when idle or on the end byte
   `SDHFE_ASSERT_NOW(a_take_when_free, clock, reset, take,
      advance && (!active_ff || phase_ff == PH_END))

endmodule

FILE: rtl/secded_hamming_frame_encoder.sv
// Top level of the secded hamming frame encoder.
// Depends on sdhfe_pkg, sdhfe_codeword and sdhfe_framer.
//
// Usage: a request carries a 10-byte message on req_message_high (bytes 0..7)
// and req_message_low (bytes 8..9). The message is spread over a 128-bit
// extended hamming codeword and sent on the rsp channel one byte per cycle while
// rsp_ready is high: 0xAA, the 16 codeword bytes with 0xDD ahead of any 0xAA/0xBB/0xDD byte,
// then 0xBB with rsp_frame_last high. A frame is 18 to 34 bytes long.
// Path: a request passes through the request register, the framer's codeword
// register and the output register before its start byte reaches rsp. The
// throughput is one frame byte per cycle while rsp_ready is high, set by the
// single byte-wide output port. A request register takes the next message while
// the current frame is still going out, so frames follow each other back to back.
// When rsp_ready is low the output register holds its byte and the
// sequencer stalls; req_ready drops once the request register is full.
// Synchronous reset drops any message in flight and clears both valids.
module secded_hamming_frame_encoder
   import sdhfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [HIGH_BITS-1:0]  req_message_high,
   input  logic [LOW_BITS-1:0]   req_message_low,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_frame_byte,
   output logic                  rsp_frame_last
);

   logic                 hold_valid_ff, hold_valid_in;
   logic [HIGH_BITS-1:0] hold_high_ff, hold_high_in;
   logic [LOW_BITS-1:0]  hold_low_ff, hold_low_in;
   logic                 take;
   cw_offer_type         offer;

   // request register, freed when the framer takes its codeword
   assign req_ready = !hold_valid_ff || take;

   always_comb begin
      hold_valid_in = hold_valid_ff && !take;
      hold_high_in  = hold_high_ff;
      hold_low_in   = hold_low_ff;
      if (req_valid && req_ready) begin
         hold_valid_in = 1'b1;
         hold_high_in  = req_message_high;
         hold_low_in   = req_message_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_high_ff <= hold_high_in;
      hold_low_ff  <= hold_low_in;
   end

   // codeword built straight from the request register
   sdhfe_codeword u_codeword (
      .msg_valid (hold_valid_ff),
      .msg_high  (hold_high_ff),
      .msg_low   (hold_low_ff),
      .offer     (offer)
   );

   // framing and output register
   sdhfe_framer u_framer (
      .clock          (clock),
      .reset          (reset),
      .offer          (offer),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
